FILE: hdl/rmtr_pkg.sv
// Shared types and constants for the Manchester tag reader core.
// Used by the front, back, top level and checker; depends on nothing.
package rmtr_pkg;

  localparam logic [1:0] KIND_EDGE   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_SAVE = 2'd2;

  localparam logic [2:0] REG_BIT_TICKS    = 3'd0;
  localparam logic [2:0] REG_SYNC_TOL     = 3'd1;
  localparam logic [2:0] REG_COIL_MODE    = 3'd2;
  localparam logic [2:0] REG_DUTY_PERIOD  = 3'd3;
  localparam logic [2:0] REG_ON_THRESHOLD = 3'd4;

  localparam logic [9:0] RST_BIT_TICKS    = 10'd256;
  localparam logic [7:0] RST_SYNC_TOL     = 8'd32;
  localparam logic [1:0] RST_COIL_MODE    = MODE_SAVE;
  localparam logic [7:0] RST_DUTY_PERIOD  = 8'd50;
  localparam logic [7:0] RST_ON_THRESHOLD = 8'd10;

  localparam logic [2:0] SYNC_COUNT    = 3'd7;
  localparam logic [3:0] ROWS          = 4'd10;
  localparam logic [2:0] ROW_LEN       = 3'd5;
  localparam logic [3:0] TIMEOUT_TICKS = 4'd10;

  typedef struct packed {
    logic [9:0] bit_ticks;
    logic [7:0] sync_tol;
    logic [1:0] coil_mode;
    logic [7:0] duty_period;
    logic [7:0] on_threshold;
  } cfg_t;

  typedef struct packed {
    logic        is_edge;
    logic        is_sample;
    logic        is_tick;
    logic [15:0] interval;
    logic        bit_value;
  } event_t;

  typedef struct packed {
    logic        coil_on;
    logic        sampling_active;
    logic        sense_falling;
    logic        preset_valid;
    logic [9:0]  timer_preset;
    logic        tag_valid;
    logic [39:0] tag_id;
    logic        parity_error;
    logic        tag_lost;
  } result_t;

endpackage

FILE: hdl/rmtr_front.sv
// Front end: accepts events, classifies them by kind and holds them in a
// two-entry queue for the back end. Depends on rmtr_pkg.
module rmtr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           kind,
  input  logic [15:0]          interval,
  input  logic                 bit_value,
  output logic                 evt_valid,
  input  logic                 evt_take,
  output rmtr_pkg::event_t     evt
);

  rmtr_pkg::event_t mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             accept;
  logic             take;
  rmtr_pkg::event_t classified;

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign evt_valid = (count != 2'd0);
  assign take      = evt_take && evt_valid;
  assign evt       = mem[rptr];

  always_comb begin
    classified.is_edge   = (kind == rmtr_pkg::KIND_EDGE);
    classified.is_sample = (kind == rmtr_pkg::KIND_SAMPLE);
    classified.is_tick   = (kind == rmtr_pkg::KIND_TICK);
    classified.interval  = interval;
    classified.bit_value = bit_value;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) begin
        wptr <= ~wptr;
      end
      if (take) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, accept} - {1'b0, take};
    end
  end

endmodule

FILE: hdl/rmtr_back.sv
// Back end: sync search, row collection, duty and timeout state, and the
// two-entry result queue. Depends on rmtr_pkg.
module rmtr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rmtr_pkg::cfg_t       cfg,
  input  logic                 evt_valid,
  output logic                 evt_take,
  input  rmtr_pkg::event_t     evt,
  output logic                 empty,
  input  logic                 pop,
  output rmtr_pkg::result_t    res
);

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_HALF   = 2'd1;
  localparam logic [1:0] PH_LONG   = 2'd2;
  localparam logic [1:0] PH_SAMPLE = 2'd3;

  logic [1:0]  sync_phase, sync_phase_next;
  logic [2:0]  good_count, good_count_next;
  logic [39:0] nibbles, nibbles_next;
  logic [4:0]  row_bits, row_bits_next;
  logic [2:0]  bit_in_row, bit_in_row_next;
  logic [3:0]  row_number, row_number_next;
  logic [2:0]  ones_in_row, ones_in_row_next;
  logic        edge_falling, edge_falling_next;
  logic [3:0]  no_sync_ticks, no_sync_ticks_next;
  logic [7:0]  duty_count, duty_count_next;

  rmtr_pkg::result_t r;
  rmtr_pkg::result_t mem [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        count;
  logic              popped;
  logic              take;

  logic        coil_before;
  logic [8:0]  half;
  logic [7:0]  quarter;
  logic [10:0] lo_lim;
  logic [10:0] hi_lim;
  logic [10:0] half_lim;
  logic [10:0] quarter_lim;
  logic [9:0]  long_preset;
  logic        in_window;
  logic [2:0]  data_ones;
  logic        mode_off;

  assign popped   = pop && !empty;
  assign empty    = (count == 2'd0);
  assign evt_take = (count != 2'd2) || popped;
  assign take     = evt_take && evt_valid;
  assign res      = mem[rptr];

  assign half        = cfg.bit_ticks[9:1];
  assign quarter     = cfg.bit_ticks[9:2];
  assign lo_lim      = (cfg.bit_ticks > {2'b0, cfg.sync_tol}) ?
                       ({1'b0, cfg.bit_ticks} - {3'b0, cfg.sync_tol}) : 11'd0;
  assign hi_lim      = {1'b0, cfg.bit_ticks} + {3'b0, cfg.sync_tol};
  assign half_lim    = {2'b0, half} + {3'b0, cfg.sync_tol};
  assign quarter_lim = {3'b0, quarter} + {3'b0, cfg.sync_tol};
  assign long_preset = cfg.bit_ticks - {2'b0, quarter};
  assign in_window   = (evt.interval >= {5'b0, lo_lim}) && (evt.interval <= {5'b0, hi_lim});
  assign mode_off    = (cfg.coil_mode == rmtr_pkg::MODE_OFF);

  always_comb begin
    case (cfg.coil_mode)
      rmtr_pkg::MODE_OFF:  coil_before = 1'b0;
      rmtr_pkg::MODE_SAVE: coil_before = (duty_count <= cfg.on_threshold);
      default:             coil_before = 1'b1;
    endcase
  end

  always_comb begin
    sync_phase_next    = sync_phase;
    good_count_next    = good_count;
    nibbles_next       = nibbles;
    row_bits_next      = row_bits;
    bit_in_row_next    = bit_in_row;
    row_number_next    = row_number;
    ones_in_row_next   = ones_in_row;
    edge_falling_next  = edge_falling;
    no_sync_ticks_next = no_sync_ticks;
    duty_count_next    = duty_count;
    data_ones          = 3'd0;
    r                  = '0;

    if (mode_off) begin
      sync_phase_next  = PH_SEARCH;
      good_count_next  = 3'd0;
      row_bits_next    = 5'd0;
      bit_in_row_next  = 3'd0;
      row_number_next  = 4'd0;
      ones_in_row_next = 3'd0;
    end

    if (evt.is_edge && !mode_off) begin
      case (sync_phase)
        PH_SEARCH: begin
          if (in_window) begin
            good_count_next = good_count + 3'd1;
            if (good_count_next == rmtr_pkg::SYNC_COUNT) begin
              sync_phase_next   = PH_HALF;
              edge_falling_next = 1'b1;
            end
          end else begin
            good_count_next = 3'd0;
          end
        end
        PH_HALF: begin
          edge_falling_next = 1'b0;
          if ({5'b0, half_lim} > evt.interval) begin
            sync_phase_next    = PH_LONG;
            no_sync_ticks_next = 4'd0;
          end else begin
            sync_phase_next  = PH_SEARCH;
            good_count_next  = 3'd0;
            row_bits_next    = 5'd0;
            bit_in_row_next  = 3'd0;
            row_number_next  = 4'd0;
            ones_in_row_next = 3'd0;
          end
        end
        PH_LONG: begin
          sync_phase_next  = (evt.interval > {5'b0, half_lim}) ? PH_SAMPLE : PH_SEARCH;
          good_count_next  = 3'd0;
          row_bits_next    = 5'd0;
          bit_in_row_next  = 3'd0;
          row_number_next  = 4'd0;
          ones_in_row_next = 3'd0;
          if (evt.interval > {5'b0, half_lim}) begin
            nibbles_next   = 40'd0;
            r.preset_valid = 1'b1;
            r.timer_preset = long_preset;
          end
        end
        default: begin
          r.preset_valid = 1'b1;
          r.timer_preset = ({5'b0, quarter_lim} > evt.interval) ? {2'b0, quarter}
                                                                 : long_preset;
        end
      endcase
    end else if (evt.is_sample && !mode_off && sync_phase == PH_SAMPLE) begin
      if (row_number < rmtr_pkg::ROWS) begin
        if (evt.bit_value) begin
          row_bits_next    = row_bits | (5'b1 << (3'd4 - bit_in_row));
          ones_in_row_next = ones_in_row + 3'd1;
        end
        bit_in_row_next = bit_in_row + 3'd1;
        if (bit_in_row_next == rmtr_pkg::ROW_LEN) begin
          data_ones = ones_in_row_next - {2'b0, evt.bit_value};
          if (data_ones[0] == evt.bit_value) begin
            nibbles_next     = {nibbles[35:0], row_bits_next[4:1]};
            row_number_next  = row_number + 4'd1;
            row_bits_next    = 5'd0;
            bit_in_row_next  = 3'd0;
            ones_in_row_next = 3'd0;
          end else begin
            r.parity_error   = 1'b1;
            sync_phase_next  = PH_SEARCH;
            good_count_next  = 3'd0;
            row_bits_next    = 5'd0;
            bit_in_row_next  = 3'd0;
            row_number_next  = 4'd0;
            ones_in_row_next = 3'd0;
          end
        end
      end else begin
        r.tag_valid      = 1'b1;
        r.tag_id         = nibbles;
        sync_phase_next  = PH_SEARCH;
        good_count_next  = 3'd0;
        row_bits_next    = 5'd0;
        bit_in_row_next  = 3'd0;
        row_number_next  = 4'd0;
        ones_in_row_next = 3'd0;
      end
    end else if (evt.is_tick) begin
      duty_count_next = (duty_count == 8'd0) ? cfg.duty_period : duty_count - 8'd1;
      if (coil_before && no_sync_ticks < rmtr_pkg::TIMEOUT_TICKS) begin
        no_sync_ticks_next = no_sync_ticks + 4'd1;
        if (no_sync_ticks_next == rmtr_pkg::TIMEOUT_TICKS) begin
          r.tag_lost       = 1'b1;
          sync_phase_next  = PH_SEARCH;
          good_count_next  = 3'd0;
          row_bits_next    = 5'd0;
          bit_in_row_next  = 3'd0;
          row_number_next  = 4'd0;
          ones_in_row_next = 3'd0;
        end
      end
    end

    case (cfg.coil_mode)
      rmtr_pkg::MODE_OFF:  r.coil_on = 1'b0;
      rmtr_pkg::MODE_SAVE: r.coil_on = (duty_count_next <= cfg.on_threshold);
      default:             r.coil_on = 1'b1;
    endcase
    r.sampling_active = (sync_phase_next == PH_SAMPLE);
    r.sense_falling   = edge_falling_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mem[wptr] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_phase    <= PH_SEARCH;
      good_count    <= 3'd0;
      nibbles       <= 40'd0;
      row_bits      <= 5'd0;
      bit_in_row    <= 3'd0;
      row_number    <= 4'd0;
      ones_in_row   <= 3'd0;
      edge_falling  <= 1'b0;
      no_sync_ticks <= 4'd0;
      duty_count    <= 8'd0;
      wptr          <= 1'b0;
      rptr          <= 1'b0;
      count         <= 2'd0;
    end else begin
      if (take) begin
        sync_phase    <= sync_phase_next;
        good_count    <= good_count_next;
        nibbles       <= nibbles_next;
        row_bits      <= row_bits_next;
        bit_in_row    <= bit_in_row_next;
        row_number    <= row_number_next;
        ones_in_row   <= ones_in_row_next;
        edge_falling  <= edge_falling_next;
        no_sync_ticks <= no_sync_ticks_next;
        duty_count    <= duty_count_next;
        wptr          <= ~wptr;
      end
      if (popped) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, take} - {1'b0, popped};
    end
  end

endmodule

FILE: hdl/rfid_manchester_tag_reader_core.sv
// Top level of the Manchester tag reader: configuration registers, front
// end and back end. Depends on rmtr_pkg, rmtr_front and rmtr_back.
// Each event passes through the front-end queue and then the back-end result queue
// before its result appears on the output ports.
// Throughput: one event per cycle while the result queue has room or is popped.
// Reset clears all decoder state and both queues and loads register defaults.
module rfid_manchester_tag_reader_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [15:0] interval,
  input  logic        bit_value,
  output logic        empty,
  input  logic        pop,
  output logic        coil_on,
  output logic        sampling_active,
  output logic        sense_falling,
  output logic        preset_valid,
  output logic [9:0]  timer_preset,
  output logic        tag_valid,
  output logic [39:0] tag_id,
  output logic        parity_error,
  output logic        tag_lost,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  rmtr_pkg::cfg_t    cfg;
  rmtr_pkg::event_t  evt;
  rmtr_pkg::result_t res;
  logic              evt_valid;
  logic              evt_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_ticks    <= rmtr_pkg::RST_BIT_TICKS;
      cfg.sync_tol     <= rmtr_pkg::RST_SYNC_TOL;
      cfg.coil_mode    <= rmtr_pkg::RST_COIL_MODE;
      cfg.duty_period  <= rmtr_pkg::RST_DUTY_PERIOD;
      cfg.on_threshold <= rmtr_pkg::RST_ON_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rmtr_pkg::REG_BIT_TICKS:    cfg.bit_ticks    <= cfg_data;
        rmtr_pkg::REG_SYNC_TOL:     cfg.sync_tol     <= cfg_data[7:0];
        rmtr_pkg::REG_COIL_MODE:    cfg.coil_mode    <= cfg_data[1:0];
        rmtr_pkg::REG_DUTY_PERIOD:  cfg.duty_period  <= cfg_data[7:0];
        rmtr_pkg::REG_ON_THRESHOLD: cfg.on_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rmtr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .interval  (interval),
    .bit_value (bit_value),
    .evt_valid (evt_valid),
    .evt_take  (evt_take),
    .evt       (evt)
  );

  rmtr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .evt_valid (evt_valid),
    .evt_take  (evt_take),
    .evt       (evt),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign coil_on         = res.coil_on;
  assign sampling_active = res.sampling_active;
  assign sense_falling   = res.sense_falling;
  assign preset_valid    = res.preset_valid;
  assign timer_preset    = res.timer_preset;
  assign tag_valid       = res.tag_valid;
  assign tag_id          = res.tag_id;
  assign parity_error    = res.parity_error;
  assign tag_lost        = res.tag_lost;

endmodule

FILE: hdl/rmtr_checker.sv
// Port-level checks for the Manchester tag reader core, bound to the top level.
// Depends only on the ports of rfid_manchester_tag_reader_core.
module rmtr_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        preset_valid,
  input logic [9:0]  timer_preset,
  input logic        tag_valid,
  input logic [39:0] tag_id,
  input logic        parity_error,
  input logic        tag_lost
);

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_one_event_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((tag_valid + parity_error + preset_valid + tag_lost) <= 3'd1))
    else $error("result beat carries more than one event outcome");

  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !tag_valid) |-> (tag_id == 40'd0))
    else $error("tag id nonzero without a delivered tag");

  a_preset_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !preset_valid) |-> (timer_preset == 10'd0))
    else $error("timer preset nonzero without preset_valid");

endmodule

bind rfid_manchester_tag_reader_core rmtr_checker u_rmtr_checker (.*);

FILE: dv/tag_reader_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Manchester tag reader core: it mirrors the decoder state,
// predicts one status report per accepted event beat and compares the popped
// beats field by field. Depends on rmtr_pkg.
module tag_reader_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  kind,
  input  logic [15:0] interval,
  input  logic        bit_value,
  input  logic        empty,
  input  logic        pop,
  input  logic        coil_on,
  input  logic        sampling_active,
  input  logic        sense_falling,
  input  logic        preset_valid,
  input  logic [9:0]  timer_preset,
  input  logic        tag_valid,
  input  logic [39:0] tag_id,
  input  logic        parity_error,
  input  logic        tag_lost,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [1:0] {HUNT, WANT_SHORT, WANT_LONG, SAMPLING} sync_phase_t;

  logic [9:0]  m_tpb;
  logic [7:0]  m_margin;
  logic [1:0]  m_mode;
  logic [7:0]  m_period;
  logic [7:0]  m_thresh;

  sync_phase_t phase;
  logic [2:0]  good_cnt;
  logic [39:0] nibbles;
  logic [4:0]  row_bits;
  logic [2:0]  bit_pos;
  logic [3:0]  row_cnt;
  logic [2:0]  ones;
  logic        falling;
  logic [3:0]  lost_ticks;
  logic [7:0]  duty;

  rmtr_pkg::result_t predicted_reports[$];
  rmtr_pkg::result_t seen;
  rmtr_pkg::result_t want;

  function automatic void clear_read();
    phase    = HUNT;
    good_cnt = '0;
    row_bits = '0;
    bit_pos  = '0;
    row_cnt  = '0;
    ones     = '0;
  endfunction

  function automatic void reset_model();
    m_tpb      = rmtr_pkg::RST_BIT_TICKS;
    m_margin   = rmtr_pkg::RST_SYNC_TOL;
    m_mode     = rmtr_pkg::RST_COIL_MODE;
    m_period   = rmtr_pkg::RST_DUTY_PERIOD;
    m_thresh   = rmtr_pkg::RST_ON_THRESHOLD;
    nibbles    = '0;
    falling    = 1'b0;
    lost_ticks = '0;
    duty       = '0;
    clear_read();
  endfunction

  function automatic logic coil_lit();
    if (m_mode == rmtr_pkg::MODE_OFF) return 1'b0;
    if (m_mode == rmtr_pkg::MODE_SAVE) return duty <= m_thresh;
    return 1'b1;
  endfunction

  function automatic rmtr_pkg::result_t decode_event(input logic [1:0] k,
                                                     input logic [15:0] iv,
                                                     input logic b);
    rmtr_pkg::result_t r;
    int unsigned       quarter;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       split;
    logic              coil_was_on;
    logic [2:0]        data_ones;
    r           = '0;
    quarter     = m_tpb / 4;
    split       = m_tpb / 2 + m_margin;
    lo          = (m_tpb > m_margin) ? m_tpb - m_margin : 0;
    hi          = m_tpb + m_margin;
    coil_was_on = coil_lit();
    if (m_mode == rmtr_pkg::MODE_OFF) clear_read();

    if (k == rmtr_pkg::KIND_EDGE && m_mode != rmtr_pkg::MODE_OFF) begin
      case (phase)
        HUNT: begin
          if (iv >= lo && iv <= hi) begin
            good_cnt = good_cnt + 3'd1;
            if (good_cnt == rmtr_pkg::SYNC_COUNT) begin
              phase   = WANT_SHORT;
              falling = 1'b1;
            end
          end else begin
            good_cnt = '0;
          end
        end
        WANT_SHORT: begin
          falling = 1'b0;
          if (iv < split) begin
            phase      = WANT_LONG;
            lost_ticks = '0;
          end else begin
            clear_read();
          end
        end
        WANT_LONG: begin
          if (iv > split) begin
            phase          = SAMPLING;
            good_cnt       = '0;
            nibbles        = '0;
            row_bits       = '0;
            bit_pos        = '0;
            row_cnt        = '0;
            ones           = '0;
            r.preset_valid = 1'b1;
            r.timer_preset = 10'(m_tpb - quarter);
          end else begin
            clear_read();
          end
        end
        default: begin
          r.preset_valid = 1'b1;
          r.timer_preset = (iv < quarter + m_margin) ? 10'(quarter) : 10'(m_tpb - quarter);
        end
      endcase
    end else if (k == rmtr_pkg::KIND_SAMPLE && m_mode != rmtr_pkg::MODE_OFF &&
                 phase == SAMPLING) begin
      if (row_cnt < rmtr_pkg::ROWS) begin
        if (b) begin
          row_bits[rmtr_pkg::ROW_LEN - 3'd1 - bit_pos] = 1'b1;
          ones = ones + 3'd1;
        end
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == rmtr_pkg::ROW_LEN) begin
          // The fifth bit must equal the parity of the four data bits.
          data_ones = ones - {2'b0, b};
          if (data_ones[0] == b) begin
            nibbles  = {nibbles[35:0], row_bits[4:1]};
            row_cnt  = row_cnt + 4'd1;
            row_bits = '0;
            bit_pos  = '0;
            ones     = '0;
          end else begin
            r.parity_error = 1'b1;
            clear_read();
          end
        end
      end else begin
        r.tag_valid = 1'b1;
        r.tag_id    = nibbles;
        clear_read();
      end
    end else if (k == rmtr_pkg::KIND_TICK) begin
      duty = (duty == 8'd0) ? m_period : duty - 8'd1;
      if (coil_was_on && lost_ticks < rmtr_pkg::TIMEOUT_TICKS) begin
        lost_ticks = lost_ticks + 4'd1;
        if (lost_ticks == rmtr_pkg::TIMEOUT_TICKS) begin
          r.tag_lost = 1'b1;
          clear_read();
        end
      end
    end

    r.coil_on         = coil_lit();
    r.sampling_active = (phase == SAMPLING);
    r.sense_falling   = falling;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] exp_v);
    fail_count++;
    if (fail_count <= 30) begin
      $display("%0t checker: %s got %0h, wanted %0h", $realtime, what, got, exp_v);
    end
  endtask

  task automatic check_report(input rmtr_pkg::result_t got, input rmtr_pkg::result_t exp_r);
    if (got.coil_on !== exp_r.coil_on)
      report_mismatch("coil_on", 40'(got.coil_on), 40'(exp_r.coil_on));
    if (got.sampling_active !== exp_r.sampling_active)
      report_mismatch("sampling_active", 40'(got.sampling_active),
                      40'(exp_r.sampling_active));
    if (got.sense_falling !== exp_r.sense_falling)
      report_mismatch("sense_falling", 40'(got.sense_falling), 40'(exp_r.sense_falling));
    if (got.preset_valid !== exp_r.preset_valid)
      report_mismatch("preset_valid", 40'(got.preset_valid), 40'(exp_r.preset_valid));
    if (got.timer_preset !== exp_r.timer_preset)
      report_mismatch("timer_preset", 40'(got.timer_preset), 40'(exp_r.timer_preset));
    if (got.tag_valid !== exp_r.tag_valid)
      report_mismatch("tag_valid", 40'(got.tag_valid), 40'(exp_r.tag_valid));
    if (got.tag_id !== exp_r.tag_id)
      report_mismatch("tag_id", got.tag_id, exp_r.tag_id);
    if (got.parity_error !== exp_r.parity_error)
      report_mismatch("parity_error", 40'(got.parity_error), 40'(exp_r.parity_error));
    if (got.tag_lost !== exp_r.tag_lost)
      report_mismatch("tag_lost", 40'(got.tag_lost), 40'(exp_r.tag_lost));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      predicted_reports.delete();
    end else begin
      if (pop && !empty) begin
        seen = {coil_on, sampling_active, sense_falling, preset_valid, timer_preset,
                tag_valid, tag_id, parity_error, tag_lost};
        if (predicted_reports.size() == 0) begin
          report_mismatch("report beat with none pending", seen.tag_id, '0);
        end else begin
          want = predicted_reports.pop_front();
          check_report(seen, want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rmtr_pkg::REG_BIT_TICKS:    m_tpb    = cfg_data;
          rmtr_pkg::REG_SYNC_TOL:     m_margin = cfg_data[7:0];
          rmtr_pkg::REG_COIL_MODE:    m_mode   = cfg_data[1:0];
          rmtr_pkg::REG_DUTY_PERIOD:  m_period = cfg_data[7:0];
          rmtr_pkg::REG_ON_THRESHOLD: m_thresh = cfg_data[7:0];
          default: ;
        endcase
      end
      if (push && !full) predicted_reports.push_back(decode_event(kind, interval, bit_value));
    end
    pending = predicted_reports.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the tag reader testbench: clock, reset, event and register stimulus
// and the verdict. Depends on rmtr_pkg, the core and tag_reader_checker.
module testbench;

  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind = rmtr_pkg::KIND_EDGE;
  logic [15:0] interval = '0;
  logic        bit_value = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        coil_on;
  logic        sampling_active;
  logic        sense_falling;
  logic        preset_valid;
  logic [9:0]  timer_preset;
  logic        tag_valid;
  logic [39:0] tag_id;
  logic        parity_error;
  logic        tag_lost;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = rmtr_pkg::REG_BIT_TICKS;
  logic [9:0]  cfg_data = '0;
  int          fail_count;
  int          pending;

  int unsigned cur_tpb = rmtr_pkg::RST_BIT_TICKS;
  int unsigned cur_margin = rmtr_pkg::RST_SYNC_TOL;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          round = 0;
  int          round_start;
  int          i;

  rfid_manchester_tag_reader_core u_dut (.*);
  tag_reader_checker u_checker (.*);

  always #1 clk = ~clk;

  always @(posedge clk) pop <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_event(input logic [1:0] k, input logic [15:0] iv, input logic b);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    kind      <= k;
    interval  <= iv;
    bit_value <= b;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned t, input int unsigned m, input logic [1:0] cm,
                            input int unsigned p, input int unsigned th);
    write_reg(rmtr_pkg::REG_BIT_TICKS, 10'(t));
    write_reg(rmtr_pkg::REG_SYNC_TOL, 10'(m));
    write_reg(rmtr_pkg::REG_COIL_MODE, 10'(cm));
    write_reg(rmtr_pkg::REG_DUTY_PERIOD, 10'(p));
    write_reg(rmtr_pkg::REG_ON_THRESHOLD, 10'(th));
    cfg_valid  <= 1'b0;
    cur_tpb    = t;
    cur_margin = m;
  endtask

  task automatic settle();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 4))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic int unsigned good_interval();
    int unsigned lo;
    int unsigned hi;
    lo = (cur_tpb > cur_margin) ? cur_tpb - cur_margin : 0;
    hi = cur_tpb + cur_margin;
    return pick_value(lo, hi);
  endfunction

  function automatic int unsigned bad_interval();
    int unsigned lo;
    int unsigned hi;
    lo = (cur_tpb > cur_margin) ? cur_tpb - cur_margin : 0;
    hi = cur_tpb + cur_margin;
    if (lo > 0 && $urandom_range(0, 1) == 1) return $urandom_range(0, lo - 1);
    return $urandom_range(hi + 1, 65535);
  endfunction

  function automatic int unsigned short_interval();
    int unsigned split;
    split = cur_tpb / 2 + cur_margin;
    return ($urandom_range(0, 3) == 0) ? split - 1 : $urandom_range(0, split - 1);
  endfunction

  function automatic int unsigned long_interval();
    int unsigned split;
    split = cur_tpb / 2 + cur_margin;
    return ($urandom_range(0, 3) == 0) ? split + 1 : $urandom_range(split + 1, 65535);
  endfunction

  // A well-formed read is seven bit-length edges, a half-bit edge, a long edge
  // and then fifty row bits plus one more sample; some reads are cut short or
  // carry a row with bad parity.
  task automatic read_tag();
    int          n;
    int          row;
    int          j;
    int unsigned cut;
    int unsigned bad_row;
    logic [3:0]  nib;
    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 9;
    for (n = 0; n < 9; n++) begin
      if (n == cut) begin
        send_event(rmtr_pkg::KIND_EDGE,
                   16'(n < 7 ? bad_interval() : (n == 7 ? long_interval()
                                                        : short_interval())), 1'b0);
        return;
      end
      send_event(rmtr_pkg::KIND_EDGE,
                 16'(n < 7 ? good_interval() : (n == 7 ? short_interval()
                                                       : long_interval())),
                 1'($urandom_range(0, 1)));
    end
    bad_row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 9) : 10;
    for (row = 0; row < 10; row++) begin
      nib = 4'($urandom_range(0, 15));
      for (j = 0; j < 4; j++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_event(rmtr_pkg::KIND_EDGE, 16'(($urandom_range(0, 1) == 1) ?
                     $urandom_range(0, cur_tpb / 4 + cur_margin) : $urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 39) == 0) begin
          send_event(rmtr_pkg::KIND_TICK, 16'($urandom), 1'($urandom));
        end
        send_event(rmtr_pkg::KIND_SAMPLE, 16'($urandom), nib[3 - j]);
      end
      send_event(rmtr_pkg::KIND_SAMPLE, 16'($urandom), (^nib) ^ (row == bad_row));
      if (row == bad_row) begin
        return;
      end
    end
    send_event(rmtr_pkg::KIND_SAMPLE, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic stir(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_event(2'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_event(rmtr_pkg::KIND_SAMPLE, 16'h0000, 1'b1);
    send_event(rmtr_pkg::KIND_EDGE, 16'hFFFF, 1'b1);
    send_event(rmtr_pkg::KIND_EDGE, 16'h0000, 1'b0);
    send_event(rmtr_pkg::KIND_TICK, 16'hFFFF, 1'b1);
    for (i = 0; i < 7; i++) begin
      send_event(rmtr_pkg::KIND_EDGE, (i % 2 == 1) ? 16'(cur_tpb + cur_margin)
                                                   : 16'(cur_tpb - cur_margin), 1'b0);
    end
    send_event(rmtr_pkg::KIND_SAMPLE, 16'h0000, 1'b1);
    send_event(rmtr_pkg::KIND_EDGE, 16'(cur_tpb / 2 + cur_margin - 1), 1'b0);
    send_event(rmtr_pkg::KIND_SAMPLE, 16'h0000, 1'b0);
    send_event(rmtr_pkg::KIND_EDGE, 16'(cur_tpb / 2 + cur_margin + 1), 1'b0);
    send_event(rmtr_pkg::KIND_EDGE, 16'h0000, 1'b0);
    send_event(rmtr_pkg::KIND_EDGE, 16'hFFFF, 1'b0);
    for (i = 0; i < 5; i++) send_event(rmtr_pkg::KIND_SAMPLE, 16'h0000, i == 0);
    settle();

    while (items_sent < 1450) begin
      case (round)
        0: set_config(16, 0, rmtr_pkg::MODE_ON, 1, 0);
        1: set_config(1023, 255, rmtr_pkg::MODE_SAVE, 255, 255);
        2: set_config($urandom_range(16, 1023), $urandom_range(0, 255), rmtr_pkg::MODE_OFF,
                      $urandom_range(1, 255), $urandom_range(0, 255));
        3: set_config(16, 255, rmtr_pkg::MODE_SAVE, 1, 0);
        default: set_config(pick_value(16, 1023), pick_value(0, 255),
                            ($urandom_range(0, 7) == 0) ? rmtr_pkg::MODE_OFF :
                            (($urandom_range(0, 1) == 1) ? rmtr_pkg::MODE_ON
                                                         : rmtr_pkg::MODE_SAVE),
                            pick_value(1, 255), pick_value(0, 255));
      endcase
      case (round % 5)
        1: begin idle_pct = 69; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 69; end
        3: begin idle_pct = 31; stall_pct = 31; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      round_start = items_sent;
      while (items_sent - round_start < 140) begin
        if ($urandom_range(0, 3) != 0) read_tag();
        stir($urandom_range(1, 6));
        if ($urandom_range(0, 7) == 0) begin
          repeat (12) send_event(rmtr_pkg::KIND_TICK, 16'($urandom), 1'($urandom));
        end
      end
      settle();
      round++;
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
